FILE: rtl/i2c_eeprom_pkg.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_pkg
// types, codes and helpers of the 24cxx eeprom page sequencer
// ----------------------------------------------------------------------------
package i2c_eeprom_pkg;

	typedef enum logic [1:0] {
		MODE_READ  = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_DATA  = 2'd2,
		MODE_REPLY = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		OP_START   = 3'd0,
		OP_STOP    = 3'd1,
		OP_SEND    = 3'd2,
		OP_RX_ACK  = 3'd3,
		OP_RX_NACK = 3'd4,
		OP_READ    = 3'd5,
		OP_OK      = 3'd6,
		OP_FAIL    = 3'd7
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_R_CTRL  = 4'd1,
		PH_R_ADDR  = 4'd2,
		PH_R_RCTRL = 4'd3,
		PH_R_DATA  = 4'd4,
		PH_W_NEED  = 4'd5,
		PH_W_POLL  = 4'd6,
		PH_W_ADDR  = 4'd7,
		PH_W_DATA  = 4'd8
	} phase_t;

	localparam logic CFG_DEVICE_ADDRESS = 1'b0;
	localparam logic CFG_POLL_LIMIT     = 1'b1;

	localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd160;
	localparam logic [7:0] POLL_LIMIT_RESET     = 8'd100;

	localparam int MAX_RESULTS = 4;

	// control byte: base, high address bits above bit 0, r/w bit
	function automatic logic [7:0] control_byte(logic [7:0] dev, logic [10:0] a, logic rw);
		control_byte = dev | {4'b0000, a[10:8], 1'b0} | {7'b0000000, rw};
	endfunction

endpackage

FILE: rtl/i2c_eeprom_page_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_page_sequencer
// master-side 24cxx eeprom sequencer above a byte-level i2c engine
// ----------------------------------------------------------------------------
// Items enter on the s_ stream: begin read, begin write, write data byte or
// bus reply. Each item is registered, then decoded against the sequencer
// state once the result buffer is free; its zero to three results (bus
// commands, read data, done ok / done fail) are loaded into a four-entry
// result buffer that drains one result per cycle while m_tready is high on
// the m_ stream, tlast on the final result of the item. An item holds the
// block until its results drain; a new item is taken in the cycle the last
// result of the previous one leaves. The user must keep PAGE_BYTES a power
// of two, unchecked by the block; the address wraps within ADDRESS_BITS.
// ----------------------------------------------------------------------------
module i2c_eeprom_page_sequencer
	import i2c_eeprom_pkg::*;
#(
	parameter int PAGE_BYTES   = 16,
	parameter int ADDRESS_BITS = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// address[10:0], length[22:11], data_byte[30:23], nack_bit[31], rx_byte[39:32]
	input  logic [39:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// op[2:0], tx_byte[10:3], rd_data[18:11], zero fill[23:19]
	output logic [23:0] m_tdata,
	output logic        m_tlast
);

	localparam int PAGE_LG = $clog2(PAGE_BYTES);

	logic [7:0] dev_q;
	logic [7:0] poll_limit_q;

	logic                    valid_s1;
	mode_t                   mode_s1;
	logic [10:0]             addr_s1;
	logic [11:0]             len_s1;
	logic [7:0]              dbyte_s1;
	logic                    nack_s1;
	logic [7:0]              rx_s1;

	phase_t                  phase_q;
	logic [ADDRESS_BITS-1:0] cur_q;
	logic [11:0]             rem_q;
	logic [7:0]              poll_q;
	logic                    first_q;
	logic [7:0]              pend_q;

	phase_t                  phase_d;
	logic [ADDRESS_BITS-1:0] cur_d;
	logic [11:0]             rem_d;
	logic [7:0]              poll_d;
	logic                    first_d;
	logic [7:0]              pend_d;

	op_t        r_op [MAX_RESULTS];
	logic [7:0] r_tx [MAX_RESULTS];
	logic [7:0] r_rd [MAX_RESULTS];
	logic [2:0] r_n;

	op_t        res_op_q [MAX_RESULTS];
	logic [7:0] res_tx_q [MAX_RESULTS];
	logic [7:0] res_rd_q [MAX_RESULTS];
	logic [2:0] cnt_q;
	logic [1:0] idx_q;

	logic        out_last;
	logic        out_fire;
	logic        buf_free;
	logic        proc;
	logic [10:0] cur_ext;
	logic [10:0] new_ext;
	logic [11:0] rem_dec;
	logic        boundary;

	assign cur_ext  = 11'(cur_q);
	assign new_ext  = 11'(addr_s1[ADDRESS_BITS-1:0]);
	assign rem_dec  = rem_q - 12'd1;
	assign boundary = (cur_ext[PAGE_LG-1:0] == '0);

	assign out_last = ({1'b0, idx_q} + 3'd1) == cnt_q;
	assign m_tvalid = (cnt_q != 3'd0);
	assign out_fire = m_tvalid && m_tready;
	assign buf_free = (cnt_q == 3'd0) || (out_fire && out_last);
	assign proc     = valid_s1 && buf_free;
	assign s_tready = !valid_s1 || buf_free;

	assign m_tdata = {5'b00000, res_rd_q[idx_q], res_tx_q[idx_q], res_op_q[idx_q]};
	assign m_tlast = out_last;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q        <= DEVICE_ADDRESS_RESET;
			poll_limit_q <= POLL_LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEVICE_ADDRESS: dev_q        <= cfg_data;
				CFG_POLL_LIMIT:     poll_limit_q <= cfg_data;
				default:            dev_q        <= dev_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1  <= mode_t'(s_tuser);
			addr_s1  <= s_tdata[10:0];
			len_s1   <= s_tdata[22:11];
			dbyte_s1 <= s_tdata[30:23];
			nack_s1  <= s_tdata[31];
			rx_s1    <= s_tdata[39:32];
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		cur_d   = cur_q;
		rem_d   = rem_q;
		poll_d  = poll_q;
		first_d = first_q;
		pend_d  = pend_q;
		case (mode_s1)
			MODE_READ: begin
				if (phase_q == PH_IDLE) begin
					cur_d   = addr_s1[ADDRESS_BITS-1:0];
					rem_d   = len_s1;
					phase_d = PH_R_CTRL;
				end
			end
			MODE_WRITE: begin
				if (phase_q == PH_IDLE) begin
					cur_d   = addr_s1[ADDRESS_BITS-1:0];
					rem_d   = len_s1;
					first_d = 1'b1;
					phase_d = (len_s1 == 12'd0) ? PH_IDLE : PH_W_NEED;
				end
			end
			MODE_DATA: begin
				if (phase_q == PH_W_NEED) begin
					pend_d = dbyte_s1;
					if (first_q || boundary) begin
						poll_d  = 8'd1;
						phase_d = PH_W_POLL;
					end else begin
						phase_d = PH_W_DATA;
					end
				end
			end
			default: begin
				case (phase_q)
					PH_R_CTRL:  phase_d = nack_s1 ? PH_IDLE : PH_R_ADDR;
					PH_R_ADDR:  phase_d = nack_s1 ? PH_IDLE : PH_R_RCTRL;
					PH_R_RCTRL: phase_d = (nack_s1 || rem_q == 12'd0) ? PH_IDLE : PH_R_DATA;
					PH_R_DATA: begin
						rem_d = rem_dec;
						if (rem_dec == 12'd0) phase_d = PH_IDLE;
					end
					PH_W_POLL: begin
						if (!nack_s1 || poll_q >= poll_limit_q) begin
							phase_d = PH_W_ADDR;
						end else begin
							poll_d = poll_q + 8'd1;
						end
					end
					PH_W_ADDR:  phase_d = nack_s1 ? PH_IDLE : PH_W_DATA;
					PH_W_DATA: begin
						if (nack_s1) begin
							phase_d = PH_IDLE;
						end else begin
							cur_d   = cur_q + 1'b1;
							rem_d   = rem_dec;
							first_d = 1'b0;
							phase_d = (rem_dec == 12'd0) ? PH_IDLE : PH_W_NEED;
						end
					end
					PH_IDLE, PH_W_NEED: phase_d = phase_q;
					default: phase_d = PH_IDLE;
				endcase
			end
		endcase
	end

	// results of the item
	always_comb begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			r_op[i] = OP_START;
			r_tx[i] = 8'd0;
			r_rd[i] = 8'd0;
		end
		r_n = 3'd0;
		case (mode_s1)
			MODE_READ: begin
				if (phase_q == PH_IDLE) begin
					r_op[0] = OP_START;
					r_op[1] = OP_SEND;
					r_tx[1] = control_byte(dev_q, new_ext, 1'b0);
					r_n     = 3'd2;
				end
			end
			MODE_WRITE: begin
				if (phase_q == PH_IDLE && len_s1 == 12'd0) begin
					r_op[0] = OP_STOP;
					r_op[1] = OP_OK;
					r_n     = 3'd2;
				end
			end
			MODE_DATA: begin
				if (phase_q == PH_W_NEED) begin
					if (first_q || boundary) begin
						r_op[0] = OP_STOP;
						r_op[1] = OP_START;
						r_op[2] = OP_SEND;
						r_tx[2] = control_byte(dev_q, cur_ext, 1'b0);
						r_n     = 3'd3;
					end else begin
						r_op[0] = OP_SEND;
						r_tx[0] = dbyte_s1;
						r_n     = 3'd1;
					end
				end
			end
			default: begin
				case (phase_q)
					PH_R_CTRL: begin
						if (nack_s1) begin
							r_op[0] = OP_STOP;
							r_op[1] = OP_FAIL;
							r_n     = 3'd2;
						end else begin
							r_op[0] = OP_SEND;
							r_tx[0] = cur_ext[7:0];
							r_n     = 3'd1;
						end
					end
					PH_R_ADDR: begin
						if (nack_s1) begin
							r_op[0] = OP_STOP;
							r_op[1] = OP_FAIL;
						end else begin
							r_op[0] = OP_START;
							r_op[1] = OP_SEND;
							r_tx[1] = control_byte(dev_q, cur_ext, 1'b1);
						end
						r_n = 3'd2;
					end
					PH_R_RCTRL: begin
						if (nack_s1) begin
							r_op[0] = OP_STOP;
							r_op[1] = OP_FAIL;
							r_n     = 3'd2;
						end else if (rem_q == 12'd0) begin
							r_op[0] = OP_STOP;
							r_op[1] = OP_OK;
							r_n     = 3'd2;
						end else begin
							r_op[0] = (rem_q == 12'd1) ? OP_RX_NACK : OP_RX_ACK;
							r_n     = 3'd1;
						end
					end
					PH_R_DATA: begin
						r_op[0] = OP_READ;
						r_rd[0] = rx_s1;
						if (rem_dec == 12'd0) begin
							r_op[1] = OP_STOP;
							r_op[2] = OP_OK;
							r_n     = 3'd3;
						end else begin
							r_op[1] = (rem_dec == 12'd1) ? OP_RX_NACK : OP_RX_ACK;
							r_n     = 3'd2;
						end
					end
					PH_W_POLL: begin
						if (!nack_s1 || poll_q >= poll_limit_q) begin
							r_op[0] = OP_SEND;
							r_tx[0] = cur_ext[7:0];
							r_n     = 3'd1;
						end else begin
							r_op[0] = OP_START;
							r_op[1] = OP_SEND;
							r_tx[1] = control_byte(dev_q, cur_ext, 1'b0);
							r_n     = 3'd2;
						end
					end
					PH_W_ADDR: begin
						if (nack_s1) begin
							r_op[0] = OP_STOP;
							r_op[1] = OP_FAIL;
							r_n     = 3'd2;
						end else begin
							r_op[0] = OP_SEND;
							r_tx[0] = pend_q;
							r_n     = 3'd1;
						end
					end
					PH_W_DATA: begin
						if (nack_s1) begin
							r_op[0] = OP_STOP;
							r_op[1] = OP_FAIL;
							r_n     = 3'd2;
						end else if (rem_dec == 12'd0) begin
							r_op[0] = OP_STOP;
							r_op[1] = OP_OK;
							r_n     = 3'd2;
						end
					end
					default: r_n = 3'd0;
				endcase
			end
		endcase
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cur_q   <= '0;
			rem_q   <= 12'd0;
			poll_q  <= 8'd0;
			first_q <= 1'b1;
			pend_q  <= 8'd0;
		end else if (proc) begin
			phase_q <= phase_d;
			cur_q   <= cur_d;
			rem_q   <= rem_d;
			poll_q  <= poll_d;
			first_q <= first_d;
			pend_q  <= pend_d;
		end
	end

	// result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (proc) begin
			cnt_q <= r_n;
			idx_q <= 2'd0;
		end else if (out_fire) begin
			if (out_last) begin
				cnt_q <= 3'd0;
				idx_q <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_op_q <= r_op;
			res_tx_q <= r_tx;
			res_rd_q <= r_rd;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 3'd0 |-> ({1'b0, idx_q} < cnt_q) && (cnt_q <= 3'd4))
		else $error("result index beyond buffer fill");

	a_drain_then_reload: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && out_last |=> !m_tvalid || $past(proc))
		else $error("results shown without a new item");

	a_poll_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_W_POLL |-> poll_q != 8'd0)
		else $error("polling without an attempt counted");

	a_busy_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !buf_free |=> valid_s1 && $stable(mode_s1))
		else $error("registered item lost while results drain");

endmodule
